>>> sv/upa_pkg.sv
// Shared types and constants of the ultrasonic proximity alarm.
package upa_pkg;

  localparam int unsigned CAPT_W     = 16;
  localparam int unsigned DIST_W     = 8;
  localparam int unsigned SCALE_W    = 16;
  localparam int unsigned PERIOD_W   = 16;
  localparam int unsigned MODE_W     = 2;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 16;

  localparam logic [DIST_W-1:0]   NEAR_RST   = 8'd10;
  localparam logic [DIST_W-1:0]   FAR_RST    = 8'd20;
  localparam logic [SCALE_W-1:0]  SCALE_RST  = 16'd131;
  localparam logic [PERIOD_W-1:0] PERIOD_RST = 16'd1000;
  localparam logic [DIST_W-1:0]   DIST_MAX   = 8'hFF;

  typedef enum logic [MODE_W-1:0] {
    MODE_OFF    = 2'd0,
    MODE_STEADY = 2'd1,
    MODE_BLINK  = 2'd2
  } mode_e;

  typedef enum logic {
    OP_EDGE = 1'b0,
    OP_TICK = 1'b1
  } op_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_NEAR_LIMIT    = 2'd0,
    REG_FAR_LIMIT     = 2'd1,
    REG_SCALE_Q16     = 2'd2,
    REG_TOGGLE_PERIOD = 2'd3
  } cfg_reg_e;

endpackage

>>> sv/upa_intf.sv
// Handshake interfaces for the event, result and configuration channels.
interface upa_in_if;
  logic                      valid;
  logic                      ready;
  logic                      operation;
  logic                      echo_level;
  logic [upa_pkg::CAPT_W-1:0] capture_time;

  modport source (output valid, operation, echo_level, capture_time, input ready);
  modport sink   (input valid, operation, echo_level, capture_time, output ready);
endinterface

interface upa_out_if;
  logic                       valid;
  logic                       ready;
  logic                       buzzer;
  logic [upa_pkg::DIST_W-1:0] distance;
  logic                       new_measurement;
  logic [upa_pkg::MODE_W-1:0] alarm_mode;

  modport source (output valid, buzzer, distance, new_measurement, alarm_mode, input ready);
  modport sink   (input valid, buzzer, distance, new_measurement, alarm_mode, output ready);
endinterface

interface upa_cfg_if;
  logic                           valid;
  logic                           ready;
  logic [upa_pkg::CFG_IDX_W-1:0]  index;
  logic [upa_pkg::CFG_DATA_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

>>> sv/ultrasonic_proximity_alarm_unit.sv
// Ultrasonic proximity alarm: echo ranging and buzzer control, top level.
//
// Channels: in_i carries one event per transaction, either an echo edge
// (operation 0, with echo_level and the captured timer value) or a buzzer
// tick (operation 1). out_o returns exactly one result per event: buzzer
// level, latest distance, a new_measurement flag and the alarm mode.
// cfg_i writes the limit, scale and toggle period registers; it is always
// ready and should be used only while no event is in flight.
// Order: the input register loads when an event is accepted, and the
// result register loads from it when the compute stage advances, which
// waits while the receiver holds off the previous result.
// Throughput: one event per cycle while the receiver takes each result;
// the rate is set by the single compute stage, one subtract, one TIME_BITS
// x 16 multiply and the distance compares between the registers.
// Reset: all measurement state clears, mode goes off, the buzzer drops and
// the registers take their defaults (10, 20, 131, 1000).
// Stall: while the receiver holds off the result, the input register still
// takes one more event; further events wait with ready low until the
// result transaction completes. No result is lost or repeated.
module ultrasonic_proximity_alarm_unit #(
  parameter int unsigned TIME_BITS = 16
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  upa_cfg_if.sink  cfg_i,
  upa_in_if.sink   in_i,
  upa_out_if.source out_o
);

  localparam int unsigned ProdW = TIME_BITS + upa_pkg::SCALE_W;

  // Configuration registers
  logic [upa_pkg::DIST_W-1:0]   near_q;
  logic [upa_pkg::DIST_W-1:0]   far_q;
  logic [upa_pkg::SCALE_W-1:0]  scale_q;
  logic [upa_pkg::PERIOD_W-1:0] period_q;

  // Input register
  logic                       in_vld_q;
  upa_pkg::op_e               op_q;
  logic                       level_q;
  logic [upa_pkg::CAPT_W-1:0] cap_q;

  // Measurement and buzzer state
  logic [TIME_BITS-1:0]         start_q, start_d;
  logic [upa_pkg::DIST_W-1:0]   last_q, last_d;
  upa_pkg::mode_e               mode_q, mode_d;
  logic                         buzz_q, buzz_d;
  logic [upa_pkg::PERIOD_W-1:0] tick_q, tick_d;

  // Result register
  logic                       out_vld_q;
  logic                       out_buzz_q;
  logic [upa_pkg::DIST_W-1:0] out_dist_q;
  logic                       out_new_q;
  upa_pkg::mode_e             out_mode_q;

  // Compute stage signals
  logic                         adv;
  logic                         fresh;
  logic [TIME_BITS-1:0]         cap_t;
  logic [TIME_BITS-1:0]         width;
  logic [ProdW-1:0]             prod;
  logic [TIME_BITS-1:0]         prod_hi;
  logic [upa_pkg::DIST_W-1:0]   dist_sat;
  logic [upa_pkg::PERIOD_W-1:0] period;
  logic [upa_pkg::PERIOD_W-1:0] tick_inc;

  // Handshakes: the compute stage advances when the result register is free
  // or being emptied this cycle.
  assign adv         = in_vld_q && (!out_vld_q || out_o.ready);
  assign in_i.ready  = !in_vld_q || adv;
  assign cfg_i.ready = 1'b1;

  // Configuration writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      near_q   <= upa_pkg::NEAR_RST;
      far_q    <= upa_pkg::FAR_RST;
      scale_q  <= upa_pkg::SCALE_RST;
      period_q <= upa_pkg::PERIOD_RST;
    end else if (cfg_i.valid) begin
      unique case (upa_pkg::cfg_reg_e'(cfg_i.index))
        upa_pkg::REG_NEAR_LIMIT:    near_q   <= cfg_i.data[upa_pkg::DIST_W-1:0];
        upa_pkg::REG_FAR_LIMIT:     far_q    <= cfg_i.data[upa_pkg::DIST_W-1:0];
        upa_pkg::REG_SCALE_Q16:     scale_q  <= cfg_i.data[upa_pkg::SCALE_W-1:0];
        upa_pkg::REG_TOGGLE_PERIOD: period_q <= cfg_i.data[upa_pkg::PERIOD_W-1:0];
        default: ;
      endcase
    end
  end

  // Input register: valid bit under reset, payload loads on acceptance
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (in_i.valid && in_i.ready) begin
      in_vld_q <= 1'b1;
    end else if (adv) begin
      in_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_i.valid && in_i.ready) begin
      op_q    <= upa_pkg::op_e'(in_i.operation);
      level_q <= in_i.echo_level;
      cap_q   <= in_i.capture_time;
    end
  end

  // Pulse width modulo 2^TIME_BITS, then scale by the Q0.16 factor
  assign cap_t    = TIME_BITS'(cap_q);
  assign width    = cap_t - start_q;
  assign prod     = ProdW'(width) * ProdW'(scale_q);
  assign prod_hi  = prod[ProdW-1:upa_pkg::SCALE_W];
  // Saturate at the top of the distance range
  assign dist_sat = (prod_hi > TIME_BITS'(upa_pkg::DIST_MAX)) ? upa_pkg::DIST_MAX
                                                              : prod_hi[upa_pkg::DIST_W-1:0];
  // A zero period behaves as one tick
  assign period   = (period_q == '0) ? upa_pkg::PERIOD_W'(1) : period_q;
  assign tick_inc = tick_q + upa_pkg::PERIOD_W'(1);

  always_comb begin
    start_d = start_q;
    last_d  = last_q;
    mode_d  = mode_q;
    buzz_d  = buzz_q;
    tick_d  = tick_q;
    fresh   = 1'b0;
    if (adv) begin
      unique case (op_q)
        upa_pkg::OP_EDGE: begin
          if (level_q) begin
            start_d = cap_t;
          end else begin
            // Classify only on two equal readings in a row
            if (dist_sat == last_q) begin
              priority if (dist_sat <= near_q) begin
                mode_d = upa_pkg::MODE_STEADY;
                buzz_d = 1'b1;
              end else if (dist_sat <= far_q) begin
                // Entering blink restarts the tick count; buzzer keeps its level
                if (mode_q != upa_pkg::MODE_BLINK) begin
                  mode_d = upa_pkg::MODE_BLINK;
                  tick_d = '0;
                end
              end else begin
                mode_d = upa_pkg::MODE_OFF;
                buzz_d = 1'b0;
              end
            end
            last_d = dist_sat;
            fresh  = 1'b1;
          end
        end
        upa_pkg::OP_TICK: begin
          // Ticks count only while blinking
          if (mode_q == upa_pkg::MODE_BLINK) begin
            tick_d = tick_inc;
            if (tick_inc >= period) begin
              tick_d = '0;
              buzz_d = !buzz_q;
            end
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start_q <= '0;
      last_q  <= '0;
      mode_q  <= upa_pkg::MODE_OFF;
      buzz_q  <= 1'b0;
      tick_q  <= '0;
    end else begin
      start_q <= start_d;
      last_q  <= last_d;
      mode_q  <= mode_d;
      buzz_q  <= buzz_d;
      tick_q  <= tick_d;
    end
  end

  // Result register: hold while the receiver stalls
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (adv) begin
      out_vld_q <= 1'b1;
    end else if (out_o.ready) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      out_buzz_q <= buzz_d;
      out_dist_q <= last_d;
      out_new_q  <= fresh;
      out_mode_q <= mode_d;
    end
  end

  assign out_o.valid           = out_vld_q;
  assign out_o.buzzer          = out_buzz_q;
  assign out_o.distance        = out_dist_q;
  assign out_o.new_measurement = out_new_q;
  assign out_o.alarm_mode      = out_mode_q;

`ifndef SYNTHESIS
  a_steady_buzz_on: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_vld_q && (out_mode_q == upa_pkg::MODE_STEADY) |-> out_buzz_q)
    else $error("steady mode with buzzer off");

  a_off_buzz_off: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_vld_q && (out_mode_q == upa_pkg::MODE_OFF) |-> !out_buzz_q)
    else $error("off mode with buzzer on");

  a_fall_flags_new: assert property (@(posedge clk_i) disable iff (!rst_ni)
    adv && (op_q == upa_pkg::OP_EDGE) && !level_q |=> out_vld_q && out_new_q)
    else $error("falling edge did not flag a new measurement");

  a_hold_when_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_vld_q && out_vld_q && !out_o.ready |-> !in_i.ready)
    else $error("input accepted while both stages are full");

  a_item_kept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_vld_q && !adv |=> in_vld_q)
    else $error("pending event dropped");
`endif

endmodule
